// ===== rtl/utf8d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths, byte class constants and the result entry type of the
// UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;

	// Result queue sizing: one byte can push up to two results.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
	localparam logic [CP_W-1:0]   BAD_CHAR   = 21'h00003F;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_end;
		logic            last_of_run;
	} result_t;

endpackage

// ===== rtl/utf8_byte_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Decodes a NUL-terminated UTF-8 byte stream into code points and end markers.
// ----------------------------------------------------------------------------
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  input   | in_valid, in_ready, in_byte                | sink
//  output  | out_valid, out_ready, code_point, is_end,  | source
//          | last_of_run                                |
//
// One byte is accepted per cycle while in_ready is high; its results are
// written to the result queue from the input register. A NUL that closes an
// open nonzero sequence pushes two results. The four-entry result queue
// decouples the sides: a stalled output fills the queue and then holds
// in_ready low. Reset clears the sequence state and the queue.
module utf8_byte_stream_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [utf8d_pkg::BYTE_W-1:0] in_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [utf8d_pkg::CP_W-1:0]   code_point,
	output logic                         is_end,
	output logic                         last_of_run
);
	import utf8d_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              step;

	logic [1:0]        pend_q;
	logic [CP_W-1:0]   part_q;
	logic [1:0]        pend_d;
	logic [CP_W-1:0]   part_d;
	logic [1:0]        pend_dec;
	logic [CP_W-1:0]   merged;
	logic [1:0]        n_push;
	result_t           res0;
	result_t           res1;

	result_t           queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	// The input stage advances only when the queue can take two results.
	assign step     = valid_s1 && (count_q <= QCNT_W'(QDEPTH - 2));
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign pend_dec = pend_q - 2'd1;

	always_comb begin
		merged = part_q;
		case (pend_dec)
			2'd0:    merged = part_q | CP_W'(byte_s1[5:0]);
			2'd1:    merged = part_q | (CP_W'(byte_s1[5:0]) << 6);
			2'd2:    merged = part_q | (CP_W'(byte_s1[5:0]) << 12);
			default: merged = part_q;
		endcase
	end

	always_comb begin
		pend_d = pend_q;
		part_d = part_q;
		n_push = 2'd0;
		res0   = '{code_point: '0, is_end: 1'b1, last_of_run: 1'b1};
		res1   = '{code_point: '0, is_end: 1'b1, last_of_run: 1'b1};
		if (byte_s1 == '0) begin
			pend_d = 2'd0;
			part_d = '0;
			if (pend_q != 2'd0 && part_q != '0) begin
				res0   = '{code_point: part_q, is_end: 1'b0, last_of_run: 1'b0};
				n_push = 2'd2;
			end else begin
				n_push = 2'd1;
			end
		end else if (pend_q != 2'd0) begin
			pend_d = pend_dec;
			if (pend_dec != 2'd0) begin
				part_d = merged;
			end else begin
				part_d = '0;
				n_push = 2'd1;
				// A completed sequence of value zero is read as end of string.
				if (merged != '0) begin
					res0 = '{code_point: merged, is_end: 1'b0, last_of_run: 1'b1};
				end
			end
		end else if (!byte_s1[7]) begin
			res0   = '{code_point: CP_W'(byte_s1), is_end: 1'b0, last_of_run: 1'b1};
			n_push = 2'd1;
		end else if ((byte_s1 & LEAD2_MASK) == LEAD2_CODE) begin
			part_d = CP_W'(byte_s1[4:0]) << 6;
			pend_d = 2'd1;
		end else if ((byte_s1 & LEAD3_MASK) == LEAD3_CODE) begin
			part_d = CP_W'(byte_s1[3:0]) << 12;
			pend_d = 2'd2;
		end else if ((byte_s1 & LEAD4_MASK) == LEAD4_CODE) begin
			part_d = CP_W'(byte_s1[2:0]) << 18;
			pend_d = 2'd3;
		end else begin
			res0   = '{code_point: BAD_CHAR, is_end: 1'b0, last_of_run: 1'b1};
			n_push = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			part_q <= '0;
		end else if (step) begin
			pend_q <= pend_d;
			part_q <= part_d;
		end
	end

	// Result queue.
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (step && n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (step && n_push == 2'd2) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (step) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(step ? n_push : 2'd0) - QCNT_W'(pop);
		end
	end

	assign out_valid   = (count_q != '0);
	assign code_point  = queue_q[rd_ptr_q].code_point;
	assign is_end      = queue_q[rd_ptr_q].is_end;
	assign last_of_run = queue_q[rd_ptr_q].last_of_run;

endmodule

// ===== rtl/utf8d_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the result stream of the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
module utf8d_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [utf8d_pkg::BYTE_W-1:0] in_byte,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [utf8d_pkg::CP_W-1:0]   code_point,
	input logic                         is_end,
	input logic                         last_of_run
);
	import utf8d_pkg::*;

	// A stalled output transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point)
			&& $stable(is_end) && $stable(last_of_run))
		else $error("output payload changed while stalled");

	// An end marker carries no code point and closes its byte's results.
	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_end |-> code_point == '0 && last_of_run)
		else $error("malformed end marker");

	// Only the flushed partial value precedes another result, and it is nonzero.
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !is_end && code_point != '0)
		else $error("bad first result of a pair");

	// A transaction that is not last is always followed by an end marker.
	a_pair_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && is_end)
		else $error("flushed partial value not followed by end marker");

	logic unused_in;
	assign unused_in = in_valid & in_ready & (|in_byte);

endmodule

bind utf8_byte_stream_decoder utf8d_checker u_utf8d_checker (.*);

// ===== sim/tb_utf8_byte_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_byte_stream_decoder
// Streams directed and random UTF-8 text into the decoder, models the
// decoder byte by byte, and checks every code point and end marker in order.
// ----------------------------------------------------------------------------
module tb_utf8_byte_stream_decoder;
	import utf8d_pkg::*;

	localparam logic [BYTE_W-1:0] NUL_BYTE     = 8'h00;
	localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
	localparam int unsigned       PHASE_ITEMS  = 290;
	localparam int unsigned       HOLD_CYCLES  = 80;
	localparam int unsigned       DRAIN_CYCLES = 20;
	localparam int unsigned       CYCLE_LIMIT  = 200000;

	// Plain ASCII, NUL on an idle decoder, two- and three-byte characters,
	// stray continuation, invalid leads, NUL inside an open sequence with a
	// nonzero and a zero partial value, overlong NUL, a lead byte taken as a
	// continuation, and the largest four-byte value.
	localparam logic [BYTE_W-1:0] OPENING_TEXT [23] = '{
		8'h41, 8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
		8'h80, 8'hF8, 8'hFF, 8'hE2, 8'h00, 8'hC0, 8'h00, 8'hC0,
		8'h80, 8'hC3, 8'hF5, 8'hF7, 8'hBF, 8'hBF, 8'hBF
	};

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] in_byte  = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CP_W-1:0]   code_point;
	logic              is_end;
	logic              last_of_run;

	// Decoder state as seen by the checker.
	logic [1:0]        seq_left = '0;
	logic [CP_W-1:0]   cp_acc   = '0;

	logic [BYTE_W-1:0] byte_backlog [$];
	result_t           cp_expected [$];

	int unsigned items_queued   = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_idle_pct  = 0;
	int unsigned hold_left      = 0;
	bit          hold_request   = 1'b0;
	bit          hold_served    = 1'b0;
	bit          byte_taken     = 1'b0;

	utf8_byte_stream_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.is_end      (is_end),
		.last_of_run (last_of_run)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void push_result(input logic [CP_W-1:0] cp, input logic fin,
			input logic last);
		result_t r;
		r.code_point  = cp;
		r.is_end      = fin;
		r.last_of_run = last;
		cp_expected.push_back(r);
	endfunction

	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		if (b == NUL_BYTE) begin
			if (seq_left != 0 && cp_acc != 0)
				push_result(cp_acc, 1'b0, 1'b0);
			push_result('0, 1'b1, 1'b1);
			seq_left = '0;
			cp_acc   = '0;
		end else if (seq_left != 0) begin
			// Any nonzero byte counts as a continuation, whatever it looks like.
			seq_left = seq_left - 2'd1;
			cp_acc   = cp_acc | (CP_W'(b[5:0]) << (6 * seq_left));
			if (seq_left == 0) begin
				// A completed sequence worth zero reads as the end of the string.
				if (cp_acc == 0)
					push_result('0, 1'b1, 1'b1);
				else
					push_result(cp_acc, 1'b0, 1'b1);
				cp_acc = '0;
			end
		end else if (!b[7]) begin
			push_result(CP_W'(b), 1'b0, 1'b1);
		end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			cp_acc   = CP_W'(b[4:0]) << 6;
			seq_left = 2'd1;
		end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			cp_acc   = CP_W'(b[3:0]) << 12;
			seq_left = 2'd2;
		end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
			cp_acc   = CP_W'(b[2:0]) << 18;
			seq_left = 2'd3;
		end else begin
			push_result(BAD_CHAR, 1'b0, 1'b1);
		end
	endfunction

	task automatic queue_byte(input logic [BYTE_W-1:0] b);
		byte_backlog.push_back(b);
		items_queued++;
	endtask

	// Queues a character of the given length with random content, sending
	// only the given number of continuation bytes after the lead.
	task automatic queue_char(input int unsigned len, input int unsigned conts);
		case (len)
			1: queue_byte(BYTE_W'($urandom_range(1, 127)));
			2: queue_byte(LEAD2_CODE | BYTE_W'($urandom_range(0, 31)));
			3: queue_byte(LEAD3_CODE | BYTE_W'($urandom_range(0, 15)));
			default: queue_byte(LEAD4_CODE | BYTE_W'($urandom_range(0, 7)));
		endcase
		repeat (conts) queue_byte(CONT_TAG | BYTE_W'($urandom_range(0, 63)));
	endtask

	task automatic queue_random_text(input int unsigned goal);
		int unsigned pick;
		int unsigned len;
		while (items_queued < goal) begin
			pick = $urandom_range(0, 99);
			len  = $urandom_range(2, 4);
			if (pick < 60) begin
				len = $urandom_range(1, 4);
				queue_char(len, len - 1);
			end else if (pick < 72) begin
				queue_byte(NUL_BYTE);
			end else if (pick < 84) begin
				queue_byte(BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 94) begin
				// Sequence cut short by a NUL or by some other byte.
				queue_char(len, $urandom_range(0, len - 2));
				if ($urandom_range(0, 3) != 0)
					queue_byte(NUL_BYTE);
				else
					queue_byte(BYTE_W'($urandom_range(0, 255)));
			end else begin
				// Overlong encoding of zero.
				case (len)
					2: queue_byte(LEAD2_CODE);
					3: queue_byte(LEAD3_CODE);
					default: queue_byte(LEAD4_CODE);
				endcase
				repeat (len - 1) queue_byte(CONT_TAG);
			end
		end
	endtask

	task automatic wait_until_quiet();
		while (byte_backlog.size() != 0 || in_valid || cp_expected.size() != 0)
			@(posedge clk);
	endtask

	// Input side: a held byte stays put until its transaction completes.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || byte_taken) begin
			if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_byte  <= byte_backlog.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_request && !hold_served) begin
			hold_left   = HOLD_CYCLES;
			hold_served = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			byte_taken = arst_n && in_valid && in_ready;
			if (byte_taken)
				decode_byte(in_byte);
			if (arst_n && out_valid && out_ready) begin
				if (cp_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual cp=%h end=%b last=%b",
						$time, code_point, is_end, last_of_run);
					mismatch_count++;
				end else begin
					want = cp_expected.pop_front();
					if (code_point !== want.code_point) begin
						$display("%0t: code_point mismatch, expected %h, actual %h",
							$time, want.code_point, code_point);
						mismatch_count++;
					end
					if (is_end !== want.is_end) begin
						$display("%0t: is_end mismatch, expected %b, actual %b",
							$time, want.is_end, is_end);
						mismatch_count++;
					end
					if (last_of_run !== want.last_of_run) begin
						$display("%0t: last_of_run mismatch, expected %b, actual %b",
							$time, want.last_of_run, last_of_run);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 23;
		recv_idle_pct = 65;
		foreach (OPENING_TEXT[i])
			queue_byte(OPENING_TEXT[i]);
		queue_random_text(items_queued + PHASE_ITEMS);
		wait_until_quiet();

		send_idle_pct = 65;
		recv_idle_pct = 23;
		queue_random_text(items_queued + PHASE_ITEMS);
		wait_until_quiet();

		// No idling here; the output side holds off for a while at the start
		// so the result queue fills and the input stalls.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request  = 1'b1;
		queue_random_text(items_queued + PHASE_ITEMS);
		wait_until_quiet();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && cp_expected.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
